// ===== sv/tmtw_pkg.sv =====
package tmtw_pkg;

    localparam int ADDR_W = 11;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BS    = 8'h08;

    localparam logic [7:0] RESET_ATTR = 8'h07;

    localparam logic CMD_PUT   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic              command;
        logic [7:0]        char_code;
        logic [ADDR_W-1:0] read_address;
    } t_in_word;

    typedef struct packed {
        logic [ADDR_W-1:0] cursor_offset;
        logic [7:0]        cell_char;
        logic [7:0]        cell_attr;
    } t_out_word;

    typedef struct packed {
        logic take;
        logic clear_start;
        logic scroll_start;
        logic scroll;
        logic blank;
        logic init;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_clear;
        logic need_scroll;
        logic scroll_done;
        logic blank_done;
    } t_dp_status;

endpackage

// ===== sv/text_mode_terminal_writer_top.sv =====
// Text console engine over a COLUMNS x ROWS screen held in two single-port-write RAMs, one
// for character bytes and one for attribute bytes. After reset the block blanks the whole
// screen, one cell per cycle (COLUMNS*ROWS cells, 2000 by default), with input ready low.
// For a put word that does not scroll, the RAM write and read are issued in the accept
// cycle, and the result is registered once the output register is free. A scroll copies
// one cell per cycle and then blanks the last row; a clear word blanks the whole screen.
// The attribute register may be written at any time; it is always ready.
module text_mode_terminal_writer_top
    import tmtw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_word,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    tmtw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tmtw_dp #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_word  (o_out_word)
    );

    assign o_cfg_ready = 1'b1;

endmodule

// ===== sv/tmtw_ram.sv =====
module tmtw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tmtw_ctrl.sv =====
module tmtw_ctrl
    import tmtw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SCROLL = 7'b0000100,
        S_BLANK  = 7'b0001000,
        S_CLEAR  = 7'b0010000,
        S_READ   = 7'b0100000,
        S_RESP   = 7'b1000000
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_INIT: begin
                cmd.blank = 1'b1;
                cmd.init  = 1'b1;
                if (i_status.blank_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.take = 1'b1;
                    if (i_status.is_clear) begin
                        cmd.clear_start = 1'b1;
                        n_state         = S_CLEAR;
                    end else if (i_status.need_scroll) begin
                        cmd.scroll_start = 1'b1;
                        n_state          = S_SCROLL;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SCROLL: begin
                cmd.scroll = 1'b1;
                if (i_status.scroll_done) begin
                    n_state = S_BLANK;
                end
            end
            S_BLANK, S_CLEAR: begin
                cmd.blank = 1'b1;
                if (i_status.blank_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/tmtw_dp.sv =====
module tmtw_dp
    import tmtw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_word   i_in_word,
    input  logic       i_cfg_valid,
    input  logic [7:0] i_cfg_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_word  o_out_word
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = $clog2(CELLS + 1);
    localparam int XW    = (AW > ADDR_W) ? AW : ADDR_W;
    localparam int RWD   = $clog2(ROWS);
    localparam int CWD   = $clog2(COLUMNS);

    localparam logic [PW-1:0]  P_FIRST_SRC = PW'(COLUMNS);
    localparam logic [PW-1:0]  P_GAP       = PW'(COLUMNS + 1);
    localparam logic [PW-1:0]  P_LAST_ROW  = PW'(COLUMNS * (ROWS - 1));
    localparam logic [PW-1:0]  P_END       = PW'(CELLS);
    localparam logic [PW-1:0]  P_LAST      = PW'(CELLS - 1);
    localparam logic [XW-1:0]  X_CELLS     = XW'(CELLS);
    localparam logic [XW-1:0]  X_COLUMNS   = XW'(COLUMNS);
    localparam logic [CWD:0]   C_COLUMNS   = (CWD + 1)'(COLUMNS);
    localparam logic [CWD:0]   C_LAST_COL  = (CWD + 1)'(COLUMNS - 1);
    localparam logic [RWD:0]   R_ROWS      = (RWD + 1)'(ROWS);
    localparam logic [RWD-1:0] R_LAST_ROW  = RWD'(ROWS - 1);

    logic [RWD-1:0] r_row;
    logic [CWD-1:0] r_col;
    logic [PW-1:0]  r_ptr;
    logic [7:0]     r_attr;
    t_in_word       r_item;
    t_out_word      r_out;

    logic [XW-1:0]  cur_idx, bs_idx, in_addr_x, item_addr_x;
    logic [CWD:0]   col_w, col_inc, col_tab, n_col_w;
    logic [RWD:0]   row_w, n_row_w;
    logic           is_print, need_scroll;
    logic [PW-1:0]  scroll_dst;

    logic           we_char, we_attr;
    logic [AW-1:0]  waddr, raddr;
    logic [7:0]     wdata_char, wdata_attr, rdata_char, rdata_attr;
    logic           item_in_range;

    assign cur_idx     = XW'(r_row) * X_COLUMNS + XW'(r_col);
    assign bs_idx      = (cur_idx == '0) ? '0 : cur_idx - XW'(1);
    assign in_addr_x   = XW'(i_in_word.read_address);
    assign item_addr_x = XW'(r_item.read_address);
    assign scroll_dst  = r_ptr - P_GAP;

    always_comb begin
        col_w    = {1'b0, r_col};
        row_w    = {1'b0, r_row};
        col_inc  = col_w + (CWD + 1)'(1);
        col_tab  = col_w + (CWD + 1)'(4);
        n_col_w  = col_w;
        n_row_w  = row_w;
        is_print = (i_in_word.char_code >= CH_SPACE) && (i_in_word.char_code < CH_DEL);
        if (is_print) begin
            if (col_inc >= C_COLUMNS) begin
                n_col_w = '0;
                n_row_w = row_w + (RWD + 1)'(1);
            end else begin
                n_col_w = col_inc;
            end
        end else begin
            case (i_in_word.char_code)
                CH_LF: begin
                    n_col_w = '0;
                    n_row_w = row_w + (RWD + 1)'(1);
                end
                CH_CR: begin
                    n_col_w = '0;
                end
                CH_TAB: begin
                    if (col_tab >= C_COLUMNS) begin
                        n_col_w = col_tab - C_COLUMNS;
                        n_row_w = row_w + (RWD + 1)'(1);
                    end else begin
                        n_col_w = col_tab;
                    end
                end
                CH_BS: begin
                    if (col_w != '0) begin
                        n_col_w = col_w - (CWD + 1)'(1);
                    end else if (row_w != '0) begin
                        n_col_w = C_LAST_COL;
                        n_row_w = row_w - (RWD + 1)'(1);
                    end
                end
                default: begin
                end
            endcase
        end
        need_scroll = (n_row_w == R_ROWS);
    end

    always_comb begin
        we_char    = 1'b0;
        we_attr    = 1'b0;
        waddr      = cur_idx[AW-1:0];
        wdata_char = CH_SPACE;
        wdata_attr = r_attr;
        if (i_cmd.blank) begin
            we_char    = 1'b1;
            we_attr    = 1'b1;
            waddr      = r_ptr[AW-1:0];
            wdata_attr = i_cmd.init ? RESET_ATTR : r_attr;
        end else if (i_cmd.scroll && (r_ptr != P_FIRST_SRC)) begin
            we_char    = 1'b1;
            we_attr    = 1'b1;
            waddr      = scroll_dst[AW-1:0];
            wdata_char = rdata_char;
            wdata_attr = rdata_attr;
        end else if (i_cmd.take && (i_in_word.command == CMD_PUT)) begin
            if (is_print) begin
                we_char    = 1'b1;
                we_attr    = 1'b1;
                wdata_char = i_in_word.char_code;
            end else if (i_in_word.char_code == CH_BS) begin
                we_char = 1'b1;
                waddr   = bs_idx[AW-1:0];
            end
        end
    end

    always_comb begin
        raddr = item_addr_x[AW-1:0];
        if (i_cmd.take) begin
            raddr = in_addr_x[AW-1:0];
        end else if (i_cmd.scroll) begin
            raddr = r_ptr[AW-1:0];
        end
    end

    tmtw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (we_char),
        .i_waddr (waddr),
        .i_wdata (wdata_char),
        .i_raddr (raddr),
        .o_rdata (rdata_char)
    );

    tmtw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_attr_ram (
        .i_clk   (i_clk),
        .i_we    (we_attr),
        .i_waddr (waddr),
        .i_wdata (wdata_attr),
        .i_raddr (raddr),
        .o_rdata (rdata_attr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_ptr  <= '0;
            r_attr <= RESET_ATTR;
        end else begin
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
            if (i_cmd.take) begin
                if (i_in_word.command == CMD_CLEAR) begin
                    r_row <= '0;
                    r_col <= '0;
                end else if (need_scroll) begin
                    r_row <= R_LAST_ROW;
                    r_col <= '0;
                end else begin
                    r_row <= n_row_w[RWD-1:0];
                    r_col <= n_col_w[CWD-1:0];
                end
            end
            if (i_cmd.clear_start) begin
                r_ptr <= '0;
            end else if (i_cmd.scroll_start) begin
                r_ptr <= P_FIRST_SRC;
            end else if (i_cmd.scroll) begin
                r_ptr <= (r_ptr == P_END) ? P_LAST_ROW : r_ptr + PW'(1);
            end else if (i_cmd.blank) begin
                r_ptr <= r_ptr + PW'(1);
            end
        end
    end

    assign item_in_range = (item_addr_x < X_CELLS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item <= i_in_word;
        end
        if (i_cmd.out_load) begin
            r_out.cursor_offset <= cur_idx[ADDR_W-1:0];
            r_out.cell_char     <= item_in_range ? rdata_char : 8'h00;
            r_out.cell_attr     <= item_in_range ? rdata_attr : 8'h00;
        end
    end

    assign o_status.is_clear    = (i_in_word.command == CMD_CLEAR);
    assign o_status.need_scroll = need_scroll;
    assign o_status.scroll_done = (r_ptr == P_END);
    assign o_status.blank_done  = (r_ptr == P_LAST);
    assign o_out_word           = r_out;

endmodule

// ===== sv/tmtw_checker.sv =====
module tmtw_checker
    import tmtw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_out_word  o_out_word
);

    localparam int  CELLS   = COLUMNS * ROWS;
    localparam bit  WRAPS   = (CELLS > (1 << ADDR_W));
    localparam logic [ADDR_W:0] L_CELLS = (ADDR_W + 1)'(CELLS);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("block not idle after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word accepted while one is in progress");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result changed");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> WRAPS || ({1'b0, o_out_word.cursor_offset} < L_CELLS))
        else $error("cursor offset beyond the screen");

endmodule

bind text_mode_terminal_writer_top tmtw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_chk (.*);
